// ===== rtl/ppid_pkg.sv =====
package ppid_pkg;

  // Fixed widths of the result fields and configuration registers.
  localparam int unsigned IVL_W    = 16;
  localparam int unsigned GAP_W    = 17;
  localparam int unsigned ACUM_W   = 24;
  localparam int unsigned BEAT_W   = 16;
  localparam int unsigned MEAN_W   = 20;
  localparam int unsigned RISE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [MEAN_W-1:0] MEAN_MAX = '1;
  localparam logic [ACUM_W-1:0] ACUM_MAX = '1;

  // Register reset values. The accumulator registers reset to a fixed
  // number of seconds worth of samples.
  localparam logic [RISE_W-1:0] RISE_RESET    = 8'd25;
  localparam int unsigned       ACUM_RESET_SEC = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RISE   = 2'd0,
    CFG_ACUM_LIMIT = 2'd1,
    CFG_ACUM_DROP  = 2'd2
  } ppid_cfg_idx_e;

  typedef struct packed {
    logic [RISE_W-1:0] min_rise_steps;
    logic [ACUM_W-1:0] acum_limit;
    logic [ACUM_W-1:0] acum_drop;
  } ppid_cfg_t;

  typedef struct packed {
    logic              interval_valid;
    logic              interval_rejected;
    logic [IVL_W-1:0]  interval_samples;
    logic [GAP_W-1:0]  interval_with_gap;
    logic              limit_reached;
    logic [ACUM_W-1:0] acum_snapshot;
    logic [BEAT_W-1:0] beat_index;
    logic [MEAN_W-1:0] mean_interval;
  } ppid_result_t;

endpackage

// ===== rtl/ppid_cfg_regs.sv =====
module ppid_cfg_regs
  import ppid_pkg::*;
#(
  parameter int unsigned SAMPLE_RATE = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ACUM_W-1:0]    cfg_data_i,
  output ppid_cfg_t            cfg_o
);

  localparam logic [ACUM_W-1:0] AcumReset = ACUM_W'(ACUM_RESET_SEC * SAMPLE_RATE);

  ppid_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_rise_steps <= RISE_RESET;
      cfg_q.acum_limit     <= AcumReset;
      cfg_q.acum_drop      <= AcumReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_RISE:   cfg_q.min_rise_steps <= cfg_data_i[RISE_W-1:0];
        CFG_ACUM_LIMIT: cfg_q.acum_limit     <= cfg_data_i;
        CFG_ACUM_DROP:  cfg_q.acum_drop      <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ppid_peak_track.sv =====
module ppid_peak_track
  import ppid_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic [RISE_W-1:0]       min_rise_i,
  output logic                    close_o,
  output logic [COUNT_WIDTH-1:0]  interval_o
);

  localparam logic [1:0] StageIdle  = 2'd0;
  localparam logic [1:0] StageArmed = 2'd1;
  localparam logic [1:0] StageClose = 2'd2;

  logic [SAMPLE_WIDTH-1:0] prev_q;
  logic [COUNT_WIDTH-1:0]  rise_q, rise_d;
  logic [COUNT_WIDTH-1:0]  ivl_q, ivl_d, ivl_base;
  logic [1:0]              stage_q, stage_d, stage_bump;
  logic                    rising;

  always_comb begin
    rising     = (sample_i >= prev_q);
    stage_bump = stage_q;
    close_o    = 1'b0;
    if (rising) begin
      rise_d = (rise_q == '1) ? rise_q : rise_q + 1'b1;
    end else begin
      rise_d = '0;
      if (rise_q >= COUNT_WIDTH'(min_rise_i)) begin
        stage_bump = stage_q + 2'd1;
      end
      close_o = (stage_bump == StageClose);
    end
    stage_d  = close_o ? StageArmed : stage_bump;
    ivl_base = close_o ? '0 : ivl_q;
    if (stage_d != StageIdle) begin
      ivl_d = (ivl_base == '1) ? ivl_base : ivl_base + 1'b1;
    end else begin
      ivl_d = ivl_base;
    end
  end

  assign interval_o = ivl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      rise_q  <= '0;
      ivl_q   <= '0;
      stage_q <= StageIdle;
    end else if (accept_i) begin
      prev_q  <= sample_i;
      rise_q  <= rise_d;
      ivl_q   <= ivl_d;
      stage_q <= stage_d;
    end
  end

endmodule

// ===== rtl/ppid_interval_eval.sv =====
module ppid_interval_eval
  import ppid_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH    = 16,
  parameter int unsigned MEAN_FRAC_BITS = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   close_i,
  input  logic [COUNT_WIDTH-1:0] interval_i,
  input  ppid_cfg_t              cfg_i,
  output ppid_result_t           result_o
);

  localparam int unsigned FxW = COUNT_WIDTH + MEAN_FRAC_BITS;
  localparam int unsigned XW  = ((FxW > MEAN_W) ? FxW : MEAN_W) + 3;
  localparam int unsigned AW  = ((COUNT_WIDTH + 1 > ACUM_W) ? COUNT_WIDTH + 1 : ACUM_W) + 1;

  logic [MEAN_W-1:0]      mean_q, mean_new;
  logic                   have_q;
  logic [COUNT_WIDTH-1:0] gap_q;
  logic [ACUM_W-1:0]      acum_q, acum_sat, acum_left;
  logic [BEAT_W-1:0]      beat_q, beat_next;

  logic [XW-1:0]          fx, mean_x, mean3, mean_sum;
  logic [COUNT_WIDTH:0]   total;
  logic [AW-1:0]          acum_sum;
  logic                   in_window, take, reject, limit;

  always_comb begin
    // Window test in fixed point: 4*I > 3*M and 2*I < 3*M.
    fx        = XW'(interval_i) << MEAN_FRAC_BITS;
    mean_x    = XW'(mean_q);
    mean3     = mean_x + (mean_x << 1);
    in_window = ((fx << 2) > mean3) && ((fx << 1) < mean3);
    take      = close_i && (!have_q || in_window);
    reject    = close_i && !take;

    mean_sum  = have_q ? ((mean_x + fx) >> 1) : fx;
    mean_new  = (mean_sum > XW'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(mean_sum);

    total     = {1'b0, interval_i} + {1'b0, gap_q};
    acum_sum  = AW'(acum_q) + AW'(total);
    acum_sat  = (acum_sum > AW'(ACUM_MAX)) ? ACUM_MAX : acum_sum[ACUM_W-1:0];
    limit     = (acum_sat >= cfg_i.acum_limit);
    acum_left = (acum_sat >= cfg_i.acum_drop) ? acum_sat - cfg_i.acum_drop : '0;
    beat_next = take ? beat_q + 1'b1 : beat_q;

    result_o.interval_valid    = take;
    result_o.interval_rejected = reject;
    result_o.interval_samples  = close_i ? IVL_W'(interval_i) : '0;
    result_o.interval_with_gap = take ? GAP_W'(total) : '0;
    result_o.limit_reached     = take && limit;
    result_o.acum_snapshot     = (take && limit) ? acum_sat : '0;
    result_o.beat_index        = beat_next;
    result_o.mean_interval     = take ? mean_new : mean_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      have_q <= 1'b0;
      gap_q  <= '0;
      acum_q <= '0;
      beat_q <= '0;
    end else if (accept_i) begin
      if (take) begin
        mean_q <= mean_new;
        have_q <= 1'b1;
        gap_q  <= '0;
        acum_q <= limit ? acum_left : acum_sat;
        beat_q <= beat_next;
      end else if (reject) begin
        gap_q  <= interval_i;
      end
    end
  end

endmodule

// ===== rtl/ppid_out_skid.sv =====
module ppid_out_skid
  import ppid_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ppid_result_t data_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output ppid_result_t data_o
);

  logic         head_vld_q, head_vld_d, skid_vld_q, skid_vld_d;
  ppid_result_t head_q, head_d, skid_q, skid_d;
  logic         pop;

  assign pop         = head_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign data_o      = head_q;

  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (pop) begin
      if (skid_vld_q) begin
        head_d     = skid_q;
        skid_vld_d = push_i;
        skid_d     = data_i;
      end else begin
        head_vld_d = push_i;
        head_d     = data_i;
      end
    end else if (push_i) begin
      if (!head_vld_q) begin
        head_vld_d = 1'b1;
        head_d     = data_i;
      end else begin
        skid_vld_d = 1'b1;
        skid_d     = data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

// ===== rtl/pulse_peak_interval_detector_core.sv =====
// A result enters the two-entry output buffer when its sample transaction is accepted and
// leaves it in order behind any older result. Throughput: one sample per cycle while the output buffer is not full;
// all per-sample work is a single combinational pass from the state registers into the output buffer.
// Reset (asynchronous, active low) clears all tracking state and the output buffer and
// loads the register defaults. No clearing pass follows reset.
module pulse_peak_interval_detector_core
  import ppid_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = 16,
  parameter int unsigned COUNT_WIDTH    = 16,
  parameter int unsigned MEAN_FRAC_BITS = 4,
  parameter int unsigned SAMPLE_RATE    = 128
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,

  // Configuration write channel.
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ACUM_W-1:0]       cfg_data_i,

  // Sample input channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,

  // Result output channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    interval_valid_o,
  output logic                    interval_rejected_o,
  output logic [IVL_W-1:0]        interval_samples_o,
  output logic [GAP_W-1:0]        interval_with_gap_o,
  output logic                    limit_reached_o,
  output logic [ACUM_W-1:0]       acum_snapshot_o,
  output logic [BEAT_W-1:0]       beat_index_o,
  output logic [MEAN_W-1:0]       mean_interval_o
);

  ppid_cfg_t              cfg;
  ppid_result_t           step_result, out_result;
  logic                   accept;
  logic                   buf_full;
  logic                   close;
  logic [COUNT_WIDTH-1:0] interval;

  // A sample transaction is taken whenever the output buffer has a free
  // slot. Since the buffer holds two results, a new sample is still taken
  // while one finished result waits on a stalled output.
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !in_stall_o;

  ppid_cfg_regs #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Peak detection: counts non-falling steps, marks a peak on the first
  // fall after enough of them, and counts samples between peaks. A peak
  // that follows an earlier one closes an interval this sample.
  ppid_peak_track #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_peak (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .min_rise_i (cfg.min_rise_steps),
    .close_o    (close),
    .interval_o (interval)
  );

  // Interval evaluation: window test against the running mean, mean
  // update, gap hold, and the saturating time accumulator with its limit.
  ppid_interval_eval #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .close_i    (close),
    .interval_i (interval),
    .cfg_i      (cfg),
    .result_o   (step_result)
  );

  ppid_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (step_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_result)
  );

  assign interval_valid_o    = out_result.interval_valid;
  assign interval_rejected_o = out_result.interval_rejected;
  assign interval_samples_o  = out_result.interval_samples;
  assign interval_with_gap_o = out_result.interval_with_gap;
  assign limit_reached_o     = out_result.limit_reached;
  assign acum_snapshot_o     = out_result.acum_snapshot;
  assign beat_index_o        = out_result.beat_index;
  assign mean_interval_o     = out_result.mean_interval;

endmodule
